[hdl/wfp_pkg.sv]
// Package for the WebSocket frame parser.
// Holds the phase and event codes, register indexes and the structs shared
// by wfp_core and websocket_frame_parser. No dependencies.
package wfp_pkg;

  localparam int unsigned ConfigIndexWidth = 2;

  localparam logic [6:0] LenCodeExt16 = 7'd126;
  localparam logic [3:0] HeadCountExt16Done = 4'd4;
  localparam logic [3:0] HeadCountExt64Done = 4'd10;

  typedef enum logic [2:0] {
    PhHead0   = 3'd0,
    PhHead1   = 3'd1,
    PhExt16   = 3'd2,
    PhExt64   = 3'd3,
    PhMask    = 3'd4,
    PhPayload = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    EvHeader   = 3'd0,
    EvComplete = 3'd1,
    EvPayload  = 3'd2,
    EvTrunc    = 3'd3,
    EvClient   = 3'd4
  } event_e;

  typedef enum logic [ConfigIndexWidth-1:0] {
    CfgUnmaskEnable = 2'd0,
    CfgClientCheck  = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic unmask_enable;
    logic client_check;
  } cfg_t;

  typedef struct packed {
    event_e      event_res;
    logic        fin_bit;
    logic [2:0]  reserved_bits;
    logic [3:0]  frame_opcode;
    logic        masked;
    logic [63:0] payload_length;
    logic [7:0]  data_out;
    logic        last_of_frame;
    logic [3:0]  header_consumed;
  } res_t;

endpackage

[hdl/wfp_core.sv]
// Frame state and per-word decode step of the WebSocket frame parser.
// Depends on wfp_pkg for the phase, event, configuration and result types.
module wfp_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          eob_i,
  input  wfp_pkg::cfg_t cfg_i,
  output wfp_pkg::res_t res_o
);

  wfp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hcount_q, hcount_d;
  logic [8:0]  head_q, head_d;
  logic [63:0] len_q, len_d;
  logic [31:0] key_q, key_d;
  logic [63:0] remain_q, remain_d;
  logic [1:0]  idx_q, idx_d;

  wfp_pkg::event_e ev;
  logic [7:0]  data;
  logic        last;
  logic        hdr_done;
  logic        len_done;
  logic [7:0]  key_byte;
  logic [3:0]  hcount_inc;

  assign key_byte   = key_q[{~idx_q, 3'b000} +: 8];
  assign hcount_inc = hcount_q + 4'd1;

  always_comb begin
    phase_d  = phase_q;
    hcount_d = hcount_q;
    head_d   = head_q;
    len_d    = len_q;
    key_d    = key_q;
    remain_d = remain_q;
    idx_d    = idx_q;
    ev       = wfp_pkg::EvHeader;
    data     = 8'd0;
    last     = 1'b0;
    hdr_done = 1'b0;
    len_done = 1'b0;

    case (phase_q)
      wfp_pkg::PhHead1: begin
        head_d[0] = byte_i[7];
        hcount_d  = 4'd2;
        if (byte_i[6:0] < wfp_pkg::LenCodeExt16) begin
          len_d    = {57'd0, byte_i[6:0]};
          len_done = 1'b1;
        end else if (byte_i[6:0] == wfp_pkg::LenCodeExt16) begin
          phase_d = wfp_pkg::PhExt16;
        end else begin
          phase_d = wfp_pkg::PhExt64;
        end
      end
      wfp_pkg::PhExt16, wfp_pkg::PhExt64: begin
        len_d    = {len_q[55:0], byte_i};
        hcount_d = hcount_inc;
        if ((phase_q == wfp_pkg::PhExt16 && hcount_inc == wfp_pkg::HeadCountExt16Done) ||
            (phase_q == wfp_pkg::PhExt64 && hcount_inc == wfp_pkg::HeadCountExt64Done)) begin
          len_done = 1'b1;
        end
      end
      wfp_pkg::PhMask: begin
        key_d    = {key_q[23:0], byte_i};
        hcount_d = hcount_inc;
        if (idx_q == 2'd3) begin
          hdr_done = 1'b1;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      wfp_pkg::PhPayload: begin
        data     = cfg_i.unmask_enable ? (byte_i ^ key_byte) : byte_i;
        idx_d    = idx_q + 2'd1;
        remain_d = remain_q - 64'd1;
        ev       = wfp_pkg::EvPayload;
        if (remain_d == 64'd0) begin
          last    = 1'b1;
          phase_d = wfp_pkg::PhHead0;
        end
      end
      default: begin
        hcount_d = 4'd1;
        head_d   = {byte_i[7], byte_i[6:4], byte_i[3:0], 1'b0};
        len_d    = 64'd0;
        key_d    = 32'd0;
        remain_d = 64'd0;
        idx_d    = 2'd0;
        phase_d  = wfp_pkg::PhHead1;
      end
    endcase

    // A masked frame still has its key to come once the length is known.
    if (len_done) begin
      if (head_d[0]) begin
        phase_d = wfp_pkg::PhMask;
        idx_d   = 2'd0;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      if (cfg_i.client_check && (head_d[7:5] != 3'd0 || !head_d[0])) begin
        ev = wfp_pkg::EvClient;
      end else begin
        ev = wfp_pkg::EvComplete;
      end
      remain_d = len_d;
      idx_d    = 2'd0;
      if (len_d == 64'd0) begin
        last    = 1'b1;
        phase_d = wfp_pkg::PhHead0;
      end else begin
        phase_d = wfp_pkg::PhPayload;
      end
    end

    res_o.fin_bit         = head_d[8];
    res_o.reserved_bits   = head_d[7:5];
    res_o.frame_opcode    = head_d[4:1];
    res_o.masked          = head_d[0];
    res_o.payload_length  = len_d;
    res_o.header_consumed = hcount_d;

    // A frame left open at the end of the buffer is dropped.
    if (eob_i && phase_d != wfp_pkg::PhHead0) begin
      ev      = wfp_pkg::EvTrunc;
      data    = 8'd0;
      last    = 1'b0;
      phase_d = wfp_pkg::PhHead0;
    end

    res_o.event_res     = ev;
    res_o.data_out      = data;
    res_o.last_of_frame = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wfp_pkg::PhHead0;
      hcount_q <= 4'd0;
      head_q   <= 9'd0;
      len_q    <= 64'd0;
      key_q    <= 32'd0;
      remain_q <= 64'd0;
      idx_q    <= 2'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      hcount_q <= hcount_d;
      head_q   <= head_d;
      len_q    <= len_d;
      key_q    <= key_d;
      remain_q <= remain_d;
      idx_q    <= idx_d;
    end
  end

endmodule

[hdl/websocket_frame_parser.sv]
// Pipeline: an accepted word is held in the input register, and its result word in the result register.
// Throughput: one byte per cycle, set by the single decode step between the
// input register and the result register; stalls on the output back up to the input.
// Reset: asynchronous, active low; clears the valid flags of both pipeline registers, sets
// unmask_enable to 1 and client_check to 0, and expects the first header byte.
// Top level of the WebSocket frame parser; depends on wfp_pkg and wfp_core.
module websocket_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  input  logic        end_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o,
  output logic        fin_bit_o,
  output logic [2:0]  reserved_bits_o,
  output logic [3:0]  frame_opcode_o,
  output logic        masked_o,
  output logic [63:0] payload_length_o,
  output logic [7:0]  data_out_o,
  output logic        last_of_frame_o,
  output logic [3:0]  header_consumed_o,
  input  logic        cfg_we_i,
  input  logic [wfp_pkg::ConfigIndexWidth-1:0] cfg_index_i,
  input  logic        cfg_data_i
);

  wfp_pkg::cfg_t cfg_q;
  wfp_pkg::res_t res_d, res_q;
  logic       in_valid_q, out_valid_q;
  logic [7:0] byte_q;
  logic       eob_q;
  logic       advance, step;

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unmask_enable <= 1'b1;
      cfg_q.client_check  <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == wfp_pkg::CfgUnmaskEnable) begin
        cfg_q.unmask_enable <= cfg_data_i;
      end
      if (cfg_index_i == wfp_pkg::CfgClientCheck) begin
        cfg_q.client_check <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= byte_in_i;
      eob_q  <= end_of_buffer_i;
    end
  end

  wfp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_q),
    .eob_i  (eob_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_res_o       = res_q.event_res;
  assign fin_bit_o         = res_q.fin_bit;
  assign reserved_bits_o   = res_q.reserved_bits;
  assign frame_opcode_o    = res_q.frame_opcode;
  assign masked_o          = res_q.masked;
  assign payload_length_o  = res_q.payload_length;
  assign data_out_o        = res_q.data_out;
  assign last_of_frame_o   = res_q.last_of_frame;
  assign header_consumed_o = res_q.header_consumed;

endmodule

[tb/wfp_decode_checker.sv]
// Checker for the WebSocket frame parser: predicts one result word per accepted
// byte and compares every field of each accepted result word in order.
// Depends on wfp_pkg for the phase, event and register codes and the result struct.
`timescale 1ns / 100ps

module wfp_decode_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  byte_in_i,
  input  logic        end_of_buffer_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  event_res_i,
  input  logic        fin_bit_i,
  input  logic [2:0]  reserved_bits_i,
  input  logic [3:0]  frame_opcode_i,
  input  logic        masked_i,
  input  logic [63:0] payload_length_i,
  input  logic [7:0]  data_out_i,
  input  logic        last_of_frame_i,
  input  logic [3:0]  header_consumed_i,
  input  logic        cfg_we_i,
  input  logic [wfp_pkg::ConfigIndexWidth-1:0] cfg_index_i,
  input  logic        cfg_data_i,
  output int          pending_o,
  output int          failures_o
);
  import wfp_pkg::*;

  localparam int PrintLimit = 40;

  logic        unmask_on;
  logic        client_strict;
  phase_e      parse_phase;
  logic [3:0]  hdr_cnt;
  logic [8:0]  frame_head;
  logic [63:0] len_acc;
  logic [31:0] mask_word;
  logic [63:0] bytes_left;
  logic [1:0]  key_idx;

  res_t expected_events_q[$];
  int   error_count = 0;

  assign failures_o = error_count;

  function automatic void clear_frame();
    hdr_cnt    = '0;
    frame_head = '0;
    len_acc    = '0;
    mask_word  = '0;
    bytes_left = '0;
    key_idx    = '0;
  endfunction

  task automatic end_header(output event_e ev, output logic last);
    ev = EvComplete;
    last = 1'b0;
    if (client_strict && (frame_head[7:5] != 3'd0 || !frame_head[0])) begin
      ev = EvClient;
    end
    bytes_left = len_acc;
    key_idx = '0;
    if (bytes_left == 64'd0) begin
      last = 1'b1;
      parse_phase = PhHead0;
    end else begin
      parse_phase = PhPayload;
    end
  endtask

  task automatic end_length(output event_e ev, output logic last);
    if (frame_head[0]) begin
      parse_phase = PhMask;
      key_idx = '0;
      ev = EvHeader;
      last = 1'b0;
    end else begin
      end_header(ev, last);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eob, output res_t r);
    event_e     ev;
    logic [7:0] data;
    logic [7:0] key_byte;
    logic       last;
    int         shift;
    ev = EvHeader;
    data = '0;
    last = 1'b0;
    case (parse_phase)
      PhHead1: begin
        frame_head[0] = b[7];
        hdr_cnt = 4'd2;
        if (b[6:0] < LenCodeExt16) begin
          len_acc = 64'(b[6:0]);
          end_length(ev, last);
        end else if (b[6:0] == LenCodeExt16) begin
          parse_phase = PhExt16;
        end else begin
          parse_phase = PhExt64;
        end
      end
      PhExt16, PhExt64: begin
        len_acc = {len_acc[55:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if ((parse_phase == PhExt16 && hdr_cnt == HeadCountExt16Done) ||
            (parse_phase == PhExt64 && hdr_cnt == HeadCountExt64Done)) begin
          end_length(ev, last);
        end
      end
      PhMask: begin
        mask_word = {mask_word[23:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (key_idx == 2'd3) begin
          end_header(ev, last);
        end else begin
          key_idx = key_idx + 2'd1;
        end
      end
      PhPayload: begin
        shift = 24 - 8 * int'(key_idx);
        key_byte = 8'(mask_word >> shift);
        data = unmask_on ? (b ^ key_byte) : b;
        key_idx = key_idx + 2'd1;
        bytes_left = bytes_left - 64'd1;
        ev = EvPayload;
        if (bytes_left == 64'd0) begin
          last = 1'b1;
          parse_phase = PhHead0;
        end
      end
      default: begin
        clear_frame();
        frame_head = {b[7], b[6:4], b[3:0], 1'b0};
        hdr_cnt = 4'd1;
        parse_phase = PhHead1;
      end
    endcase

    if (eob && parse_phase != PhHead0) begin
      ev = EvTrunc;
      data = '0;
      last = 1'b0;
    end

    r.event_res       = ev;
    r.fin_bit         = frame_head[8];
    r.reserved_bits   = frame_head[7:5];
    r.frame_opcode    = frame_head[4:1];
    r.masked          = frame_head[0];
    r.payload_length  = len_acc;
    r.data_out        = data;
    r.last_of_frame   = last;
    r.header_consumed = hdr_cnt;

    if (ev == EvTrunc) begin
      parse_phase = PhHead0;
      clear_frame();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < PrintLimit) begin
      $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    error_count++;
  endtask

  task automatic compare_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t predicted;
    res_t oldest;
    if (!rst_ni) begin
      unmask_on = 1'b1;
      client_strict = 1'b0;
      parse_phase = PhHead0;
      clear_frame();
      expected_events_q.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        decode_byte(byte_in_i, end_of_buffer_i, predicted);
        expected_events_q.push_back(predicted);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_events_q.size() == 0) begin
          report_mismatch("unexpected result word, event", 64'(event_res_i), 64'd0);
        end else begin
          oldest = expected_events_q.pop_front();
          compare_field("event", 64'(event_res_i), 64'(oldest.event_res));
          compare_field("fin", 64'(fin_bit_i), 64'(oldest.fin_bit));
          compare_field("rsv", 64'(reserved_bits_i), 64'(oldest.reserved_bits));
          compare_field("opcode", 64'(frame_opcode_i), 64'(oldest.frame_opcode));
          compare_field("mask bit", 64'(masked_i), 64'(oldest.masked));
          compare_field("payload length", payload_length_i, oldest.payload_length);
          compare_field("data", 64'(data_out_i), 64'(oldest.data_out));
          compare_field("last of frame", 64'(last_of_frame_i), 64'(oldest.last_of_frame));
          compare_field("header consumed", 64'(header_consumed_i),
                        64'(oldest.header_consumed));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgUnmaskEnable: unmask_on = cfg_data_i;
          CfgClientCheck:  client_strict = cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= expected_events_q.size();
    end
  end

endmodule

[tb/websocket_frame_parser_test.sv]
// Top of the WebSocket frame parser testbench: clock, reset, byte stimulus,
// register writes, flow control and the verdict. Depends on wfp_pkg,
// websocket_frame_parser and wfp_decode_checker.
`timescale 1ns / 100ps

module websocket_frame_parser_test;
  import wfp_pkg::*;

  localparam int StallLimit = 4000;
  localparam int HoldCycles = 300;
  localparam int PhaseCount = 8;
  localparam int WordsPerPhase = 85;
  localparam logic [6:0] LenCodeExt64 = 7'd127;
  localparam logic [ConfigIndexWidth-1:0] CfgSpareA = 2'd2;
  localparam logic [ConfigIndexWidth-1:0] CfgSpareB = 2'd3;

  typedef enum int {LenShort, Len16, Len64} len_form_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_in = 8'd0;
  logic        eob = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_res;
  logic        fin_bit;
  logic [2:0]  reserved_bits;
  logic [3:0]  frame_opcode;
  logic        masked;
  logic [63:0] payload_length;
  logic [7:0]  data_out;
  logic        last_of_frame;
  logic [3:0]  header_consumed;
  logic        cfg_we = 1'b0;
  logic [ConfigIndexWidth-1:0] cfg_index = CfgUnmaskEnable;
  logic        cfg_data = 1'b0;

  int pending;
  int failures;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  bit hold_request = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  websocket_frame_parser i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .byte_in_i         (byte_in),
    .end_of_buffer_i   (eob),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .event_res_o       (event_res),
    .fin_bit_o         (fin_bit),
    .reserved_bits_o   (reserved_bits),
    .frame_opcode_o    (frame_opcode),
    .masked_o          (masked),
    .payload_length_o  (payload_length),
    .data_out_o        (data_out),
    .last_of_frame_o   (last_of_frame),
    .header_consumed_o (header_consumed),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  wfp_decode_checker i_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .byte_in_i         (byte_in),
    .end_of_buffer_i   (eob),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .event_res_i       (event_res),
    .fin_bit_i         (fin_bit),
    .reserved_bits_i   (reserved_bits),
    .frame_opcode_i    (frame_opcode),
    .masked_i          (masked),
    .payload_length_i  (payload_length),
    .data_out_i        (data_out),
    .last_of_frame_i   (last_of_frame),
    .header_consumed_i (header_consumed),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .pending_o         (pending),
    .failures_o        (failures)
  );

  task automatic send_word(input logic [7:0] b, input logic last_in_buffer);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= b;
    eob <= last_in_buffer;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ConfigIndexWidth-1:0] idx, input logic value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A negative cut sends the whole frame; otherwise the buffer ends at byte cut.
  task automatic send_frame(input logic [7:0] head0, input logic with_key,
                            input len_form_e form, input logic [63:0] len,
                            input logic [31:0] key_word, input int cut);
    logic [7:0] frame_q[$];
    logic [6:0] code;
    int         total;
    code = (form == LenShort) ? len[6:0] : (form == Len16) ? LenCodeExt16 : LenCodeExt64;
    frame_q.push_back(head0);
    frame_q.push_back({with_key, code});
    if (form == Len16) begin
      for (int i = 1; i >= 0; i--) frame_q.push_back(len[8*i +: 8]);
    end
    if (form == Len64) begin
      for (int i = 7; i >= 0; i--) frame_q.push_back(len[8*i +: 8]);
    end
    if (with_key) begin
      for (int i = 3; i >= 0; i--) frame_q.push_back(key_word[8*i +: 8]);
    end
    total = (cut >= 0) ? cut + 1 : frame_q.size() + int'(len);
    while (frame_q.size() < total) frame_q.push_back(8'($urandom_range(255)));
    frames_sent++;
    for (int i = 0; i < total; i++) begin
      send_word(frame_q[i], (i == total - 1) && (cut >= 0 || $urandom_range(3) == 0));
    end
  endtask

  task automatic random_frame();
    int          pick;
    int          head_len;
    int          cut;
    len_form_e   form;
    logic [63:0] len;
    logic        with_key;
    logic        huge;
    pick = $urandom_range(99);
    if (pick < 5) begin
      send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
    end else begin
      form = (pick < 70) ? LenShort : (pick < 85) ? Len16 : Len64;
      huge = (form != LenShort) && ($urandom_range(3) == 0);
      case (form)
        LenShort: len = $urandom_range(1) ? 64'($urandom_range(8)) : 64'($urandom_range(125));
        Len16:    len = huge ? 64'($urandom_range(65535)) : 64'($urandom_range(40));
        default:  len = huge ? {$urandom, $urandom} : 64'($urandom_range(40));
      endcase
      with_key = ($urandom_range(3) != 0);
      head_len = 2 + ((form == Len16) ? 2 : (form == Len64) ? 8 : 0) + (with_key ? 4 : 0);
      cut = (huge || $urandom_range(99) < 12) ? $urandom_range(head_len + 3) : -1;
      send_frame(8'($urandom_range(255)), with_key, form, len, $urandom, cut);
    end
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout after %0d cycles without a transfer, %0d results pending",
             quiet, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase_end;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: empty frame, all-ones key, huge length cut short, early end.
    send_frame(8'h00, 1'b0, LenShort, 64'd0, 32'h0, -1);
    send_frame(8'h81, 1'b1, LenShort, 64'd3, 32'hffff_ffff, -1);
    send_frame(8'hff, 1'b1, Len64, 64'hffff_ffff_ffff_ffff, 32'h5a5a_a5a5, 14);
    send_word(8'h82, 1'b1);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      wait_drained();
      send_gap_pct = (ph % 4 == 1) ? 61 : (ph % 4 == 3) ? 16 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 61 : (ph % 4 == 3) ? 16 : 0;
      write_reg(CfgUnmaskEnable, 1'((ph & 1) ^ ((ph >> 2) & 1)));
      write_reg(CfgClientCheck, 1'((ph >> 1) & 1));
      if (ph == 3) begin
        write_reg(CfgSpareA, 1'b1);
        write_reg(CfgSpareB, 1'b1);
      end
      if (ph == 2) begin
        hold_request = 1'b1;
      end
      phase_end = bytes_sent + WordsPerPhase;
      while (bytes_sent < phase_end) random_frame();
    end

    wait_drained();
    $display("Sent %0d bytes in %0d frames over %0d phases of register settings",
             bytes_sent, frames_sent, PhaseCount);
    $display("and flow control, with short, 16-bit and 64-bit lengths, masked and %s",
             "unmasked frames, truncation and client checks.");
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
